>>> rtl/core/assert_macros.svh
// Assertion helpers; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> rtl/core/uttip_pkg.sv
package uttip_pkg;

	localparam int CODE_W     = 21;
	localparam int RESULT_W   = 64;
	localparam int BASE_W     = 6;
	localparam int DIGIT_W    = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NUMBER_BASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALLOW_PLUS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALLOW_ZERO   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_SELECT = 2'd3;

	// result width select codes
	localparam logic [1:0] WSEL_8  = 2'd0;
	localparam logic [1:0] WSEL_16 = 2'd1;
	localparam logic [1:0] WSEL_32 = 2'd2;
	localparam logic [1:0] WSEL_64 = 2'd3;

	// character codes
	localparam logic [CODE_W-1:0] CH_PLUS    = 21'h2B;
	localparam logic [CODE_W-1:0] CH_ZERO    = 21'h30;
	localparam logic [CODE_W-1:0] CH_NINE    = 21'h39;
	localparam logic [CODE_W-1:0] CH_UPPER_A = 21'h41;
	localparam logic [CODE_W-1:0] CH_UPPER_Z = 21'h5A;
	localparam logic [CODE_W-1:0] CH_LOWER_A = 21'h61;
	localparam logic [CODE_W-1:0] CH_LOWER_Z = 21'h7A;

	localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;

	typedef struct packed {
		logic [BASE_W-1:0] number_base;
		logic              allow_plus;
		logic              allow_zero;
		logic [1:0]        width_sel;
	} cfg_t;

	typedef struct packed {
		logic failed;
		logic at_start;
		logic first_zero;
		logic saw_digit;
	} flags_t;

	localparam flags_t FLAGS_RESET = '{failed: 1'b0, at_start: 1'b1,
		first_zero: 1'b0, saw_digit: 1'b0};

endpackage

>>> rtl/core/uttip_if.sv
interface uttip_char_if;
	import uttip_pkg::*;

	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] code_unit;
	logic              last_unit;

	modport source(output valid, code_unit, last_unit, input ready);
	modport sink(input valid, code_unit, last_unit, output ready);
endinterface

interface uttip_result_if;
	import uttip_pkg::*;

	logic                valid;
	logic                ready;
	logic                parse_ok;
	logic [RESULT_W-1:0] parsed_value;

	modport source(output valid, parse_ok, parsed_value, input ready);
	modport sink(input valid, parse_ok, parsed_value, output ready);
endinterface

>>> rtl/core/uttip_step.sv
// One character step: prefix checks, digit decode, multiply-add with limit check.
module uttip_step #(
	parameter int W = 64
) (
	input  uttip_pkg::cfg_t              cfg,
	input  uttip_pkg::flags_t            flags_i,
	input  logic [W-1:0]                 acc_i,
	input  logic [uttip_pkg::CODE_W-1:0] code_unit,
	input  logic                         last_unit,
	output uttip_pkg::flags_t            flags_o,
	output logic [W-1:0]                 acc_o,
	output logic                         parse_ok,
	output logic [W-1:0]                 parsed_value
);
	import uttip_pkg::*;

	logic               dig_ok;
	logic [DIGIT_W-1:0] digit;
	logic [6:0]         lim_bits;
	logic [W-1:0]       lim;
	logic [W+5:0]       prod;
	logic [W+6:0]       sum;
	logic               ovf;
	logic               take;

	// digit decode, letters case-insensitive
	always_comb begin
		dig_ok = 1'b1;
		digit  = '0;
		if (code_unit inside {[CH_ZERO:CH_NINE]}) begin
			digit = DIGIT_W'(code_unit - CH_ZERO);
		end else if (code_unit inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
			digit = DIGIT_W'(code_unit - CH_UPPER_A) + DIGIT_W'(10);
		end else if (code_unit inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
			digit = DIGIT_W'(code_unit - CH_LOWER_A) + DIGIT_W'(10);
		end else begin
			dig_ok = 1'b0;
		end
	end

	// limit of the selected width, capped at W
	always_comb begin
		case (cfg.width_sel)
			WSEL_8:  lim_bits = 7'd8;
			WSEL_16: lim_bits = 7'd16;
			WSEL_32: lim_bits = 7'd32;
			WSEL_64: lim_bits = 7'd64;
			default: lim_bits = 7'd64;
		endcase
		if (32'(lim_bits) >= W) begin
			lim = '1;
		end else begin
			lim = (W'(1) << lim_bits) - W'(1);
		end
	end

	// acc*base+d > lim  <=>  acc > (lim-d)/base
	assign prod = (W+6)'(acc_i) * (W+6)'(cfg.number_base);
	assign sum  = (W+7)'(prod) + (W+7)'(digit);
	assign ovf  = sum > (W+7)'(lim);

	always_comb begin
		flags_o      = flags_i;
		acc_o        = acc_i;
		take         = 1'b1;
		parse_ok     = 1'b0;
		parsed_value = '0;

		if (flags_i.at_start) begin
			flags_o.at_start   = 1'b0;
			flags_o.first_zero = (code_unit == CH_ZERO);
			if (code_unit == CH_PLUS) begin
				if (!cfg.allow_plus) flags_o.failed = 1'b1;
				take = 1'b0;
			end
		end else if (flags_i.first_zero) begin
			// only the very first unit is checked for a leading zero
			if (!cfg.allow_zero) flags_o.failed = 1'b1;
			flags_o.first_zero = 1'b0;
		end

		if (take && !flags_o.failed) begin
			if (!dig_ok || digit >= cfg.number_base || ovf) begin
				flags_o.failed = 1'b1;
			end else begin
				acc_o             = sum[W-1:0];
				flags_o.saw_digit = 1'b1;
			end
		end

		parse_ok     = !flags_o.failed && flags_o.saw_digit;
		parsed_value = parse_ok ? acc_o : '0;

		if (last_unit) begin
			acc_o   = '0;
			flags_o = FLAGS_RESET;
		end
	end
endmodule

>>> rtl/core/unsigned_text_to_integer_parser_unit.sv
// Timing: a request taken sits in the input stage; the character is processed
//   as it leaves that stage, and for a last character the result is registered then.
// Throughput: one character per cycle, including back-to-back strings, while held
//   results are taken; the accumulator loop (one 64x6 multiply-add and limit compare) is combinational.
// Reset (arst_n low, asynchronous): pipeline empty, string state cleared,
//   registers return to base 10, no plus, no leading zero, 64-bit limit.
`include "assert_macros.svh"

module unsigned_text_to_integer_parser_unit #(
	parameter int MAX_VALUE_BITS = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	uttip_char_if.sink                       chars,
	uttip_result_if.source                   results,
	input  logic                             cfg_we,
	input  logic [uttip_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [uttip_pkg::CFG_DATA_W-1:0] cfg_data
);
	import uttip_pkg::*;

	// configuration registers
	cfg_t cfg_q;

	// input stage: one character waiting to be processed
	logic              valid_s1;
	logic [CODE_W-1:0] code_s1;
	logic              last_s1;

	// per-string state, updated as each character leaves the input stage
	logic [MAX_VALUE_BITS-1:0] acc_q;
	flags_t                    flags_q;

	// result register
	logic                      out_valid_q;
	logic                      ok_q;
	logic [MAX_VALUE_BITS-1:0] value_q;

	// step outputs
	flags_t                    flags_n;
	logic [MAX_VALUE_BITS-1:0] acc_n;
	logic                      step_ok;
	logic [MAX_VALUE_BITS-1:0] step_value;

	logic out_free;
	logic go_s1;
	logic take_in;

	// A non-last character always moves on; a last one needs the result slot,
	// which frees in the same cycle the sink takes the held result.
	assign out_free = !out_valid_q || results.ready;
	assign go_s1    = valid_s1 && (!last_s1 || out_free);
	assign take_in  = chars.valid && chars.ready;

	assign chars.ready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.number_base <= BASE_RESET;
			cfg_q.allow_plus  <= 1'b0;
			cfg_q.allow_zero  <= 1'b0;
			cfg_q.width_sel   <= WSEL_64;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUMBER_BASE:  cfg_q.number_base <= cfg_data;
				REG_ALLOW_PLUS:   cfg_q.allow_plus  <= cfg_data[0];
				REG_ALLOW_ZERO:   cfg_q.allow_zero  <= cfg_data[0];
				REG_WIDTH_SELECT: cfg_q.width_sel   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// control of the input stage, the per-string state and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			acc_q       <= '0;
			flags_q     <= FLAGS_RESET;
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (go_s1) begin
				valid_s1 <= 1'b0;
			end

			if (go_s1) begin
				acc_q   <= acc_n;
				flags_q <= flags_n;
			end

			if (go_s1 && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take_in) begin
			code_s1 <= chars.code_unit;
			last_s1 <= chars.last_unit;
		end
		if (go_s1 && last_s1) begin
			ok_q    <= step_ok;
			value_q <= step_value;
		end
	end

	uttip_step #(
		.W(MAX_VALUE_BITS)
	) u_step (
		.cfg         (cfg_q),
		.flags_i     (flags_q),
		.acc_i       (acc_q),
		.code_unit   (code_s1),
		.last_unit   (last_s1),
		.flags_o     (flags_n),
		.acc_o       (acc_n),
		.parse_ok    (step_ok),
		.parsed_value(step_value)
	);

	assign results.valid        = out_valid_q;
	assign results.parse_ok     = ok_q;
	assign results.parsed_value = RESULT_W'(value_q);

	// a failed string reports zero
	`ASSERT_IMPL(a_fail_zero, clk, arst_n, results.valid && !results.parse_ok, results.parsed_value == '0)
	// a closed string leaves cleared state behind
	`ASSERT_NEXT(a_string_clear, clk, arst_n, go_s1 && last_s1, flags_q.at_start && acc_q == '0 && !flags_q.failed)
	// a last character blocked by a full result slot stays in the input stage
	`ASSERT_NEXT(a_hold_last, clk, arst_n, valid_s1 && last_s1 && !out_free, valid_s1 && last_s1 && out_valid_q)
endmodule

>>> verif/parse_result_checker.sv
module parse_result_checker import uttip_pkg::*; #(
	parameter int MAX_VALUE_BITS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	uttip_char_if                 chars,
	uttip_result_if               results,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic                ok;
		logic [RESULT_W-1:0] value;
	} parse_result_t;

	parse_result_t       expected_results[$];
	parse_result_t       oldest;
	cfg_t                fmt;
	flags_t              flags;
	logic [RESULT_W-1:0] accum;

	function automatic logic [RESULT_W-1:0] value_limit(input logic [1:0] wsel);
		int bits;
		case (wsel)
			WSEL_8:  bits = 8;
			WSEL_16: bits = 16;
			WSEL_32: bits = 32;
			default: bits = 64;
		endcase
		if (bits > MAX_VALUE_BITS)
			bits = MAX_VALUE_BITS;
		if (bits >= 64)
			return '1;
		return (64'd1 << bits) - 64'd1;
	endfunction

	function automatic logic digit_value(input logic [CODE_W-1:0] ch,
			output logic [RESULT_W-1:0] d);
		d = '0;
		if (ch >= CH_ZERO && ch <= CH_NINE)
			d = RESULT_W'(ch - CH_ZERO);
		else if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z)
			d = RESULT_W'(ch - CH_UPPER_A) + 64'd10;
		else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z)
			d = RESULT_W'(ch - CH_LOWER_A) + 64'd10;
		else
			return 1'b0;
		return 1'b1;
	endfunction

	// one character through the parser; a closing character yields a result
	function automatic void parse_unit(input logic [CODE_W-1:0] ch, input logic last);
		logic                take;
		logic [RESULT_W-1:0] d;
		logic [RESULT_W-1:0] lim;
		logic [RESULT_W-1:0] radix;
		parse_result_t       res;
		take = 1'b1;
		radix = RESULT_W'(fmt.number_base);
		if (flags.at_start) begin
			flags.at_start = 1'b0;
			flags.first_zero = (ch == CH_ZERO);
			if (ch == CH_PLUS) begin
				if (!fmt.allow_plus)
					flags.failed = 1'b1;
				take = 1'b0;
			end
		end else if (flags.first_zero) begin
			if (!fmt.allow_zero)
				flags.failed = 1'b1;
			flags.first_zero = 1'b0;
		end
		if (take && !flags.failed) begin
			if (!digit_value(ch, d) || d >= radix) begin
				flags.failed = 1'b1;
			end else begin
				lim = value_limit(fmt.width_sel);
				if (d > lim || accum > (lim - d) / radix) begin
					flags.failed = 1'b1;
				end else begin
					accum = accum * radix + d;
					flags.saw_digit = 1'b1;
				end
			end
		end
		if (last) begin
			res.ok = !flags.failed && flags.saw_digit;
			res.value = res.ok ? accum : '0;
			expected_results.push_back(res);
			accum = '0;
			flags = FLAGS_RESET;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt = '{number_base: BASE_RESET, allow_plus: 1'b0, allow_zero: 1'b0,
				width_sel: WSEL_64};
			flags = FLAGS_RESET;
			accum = '0;
			expected_results = {};
			mismatches = 0;
			outstanding = 0;
		end else begin
			// results first: nothing leaves the block in the cycle it enters
			if (results.valid && results.ready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result: expected none, actual ok=%0b value=%0d",
						$time, results.parse_ok, results.parsed_value);
				end else begin
					oldest = expected_results.pop_front();
					if (results.parse_ok !== oldest.ok) begin
						mismatches++;
						$display("%0t: parse_ok: expected %0b, actual %0b",
							$time, oldest.ok, results.parse_ok);
					end
					if (results.parsed_value !== oldest.value) begin
						mismatches++;
						$display("%0t: parsed_value: expected 0x%016h, actual 0x%016h",
							$time, oldest.value, results.parsed_value);
					end
				end
			end
			if (chars.valid && chars.ready)
				parse_unit(chars.code_unit, chars.last_unit);
			if (cfg_we) begin
				case (cfg_index)
					REG_NUMBER_BASE:  fmt.number_base = cfg_data[BASE_W-1:0];
					REG_ALLOW_PLUS:   fmt.allow_plus = cfg_data[0];
					REG_ALLOW_ZERO:   fmt.allow_zero = cfg_data[0];
					REG_WIDTH_SELECT: fmt.width_sel = cfg_data[1:0];
					default: ;
				endcase
			end
			outstanding = expected_results.size();
		end
	end

endmodule

>>> verif/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import uttip_pkg::*;

	localparam int VALUE_BITS  = 64;
	localparam int UNIT_TARGET = 1500;
	// past this many characters the run drops send gaps and result stalls
	localparam int CALM_AFTER  = 1300;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    outstanding;

	// stimulus state
	int                    units_sent;
	logic                  send_gaps;
	logic                  recv_stalls;
	int                    cur_base;
	logic [1:0]            cur_wsel;
	logic [CODE_W-1:0]     numeral[$];

	uttip_char_if   chars_if();
	uttip_result_if results_if();

	unsigned_text_to_integer_parser_unit #(.MAX_VALUE_BITS(VALUE_BITS)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars_if),
		.results  (results_if),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// watches both channels and the register port, predicts and compares
	parse_result_checker #(.MAX_VALUE_BITS(VALUE_BITS)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.chars      (chars_if),
		.results    (results_if),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Largest value the current width select allows, used to aim numbers at
	// the overflow boundary.
	function automatic logic [63:0] width_max(input logic [1:0] wsel);
		int bits;
		case (wsel)
			WSEL_8:  bits = 8;
			WSEL_16: bits = 16;
			WSEL_32: bits = 32;
			default: bits = 64;
		endcase
		if (bits > VALUE_BITS)
			bits = VALUE_BITS;
		return (bits >= 64) ? '1 : (64'd1 << bits) - 64'd1;
	endfunction

	// Digit value to a character; letters come in either case.
	function automatic logic [CODE_W-1:0] digit_char(input int d);
		if (d < 10)
			return CH_ZERO + CODE_W'(d);
		return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + CODE_W'(d - 10);
	endfunction

	// Anything at all: full 21-bit codes, the neighbors of the digit and letter
	// ranges or a plus sign, plain ASCII, or a digit that may sit above the base.
	function automatic logic [CODE_W-1:0] noise_unit();
		case ($urandom_range(0, 3))
			0: return CODE_W'($urandom_range(0, 21'h1FFFFF));
			1: begin
				case ($urandom_range(0, 6))
					0: return CH_ZERO - CODE_W'(1);
					1: return CH_NINE + CODE_W'(1);
					2: return CH_UPPER_A - CODE_W'(1);
					3: return CH_UPPER_Z + CODE_W'(1);
					4: return CH_LOWER_A - CODE_W'(1);
					5: return CH_LOWER_Z + CODE_W'(1);
					default: return CH_PLUS;
				endcase
			end
			2: return CODE_W'($urandom_range(0, 127));
			default: return digit_char($urandom_range(0, 35));
		endcase
	endfunction

	function automatic int digits_needed(input logic [63:0] v, input int b);
		int n;
		n = 0;
		do begin
			n++;
			v = v / 64'(b);
		end while (v != 0);
		return n;
	endfunction

	// Writes v in base b onto the end of the numeral being built.
	function automatic void append_number(input logic [63:0] v, input int b);
		logic [CODE_W-1:0] digits[$];
		digits = {};
		do begin
			digits.push_front(digit_char(int'(v % 64'(b))));
			v = v / 64'(b);
		end while (v != 0);
		foreach (digits[i])
			numeral.push_back(digits[i]);
	endfunction

	// One character request. A random gap may come first; valid then stays
	// high until the block takes the request.
	task automatic send_unit(input logic [CODE_W-1:0] code, input logic last);
		@(negedge clk);
		if (send_gaps && $urandom_range(0, 5) == 0) begin
			chars_if.valid = 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		chars_if.valid = 1'b1;
		chars_if.code_unit = code;
		chars_if.last_unit = last;
		do @(posedge clk); while (!chars_if.ready);
		units_sent++;
	endtask

	task automatic send_numeral();
		if (units_sent >= CALM_AFTER) begin
			send_gaps = 1'b0;
			recv_stalls = 1'b0;
		end
		foreach (numeral[i])
			send_unit(numeral[i], i == numeral.size() - 1);
	endtask

	task automatic send_ascii(input string s);
		numeral = {};
		for (int i = 0; i < s.len(); i++)
			numeral.push_back(CODE_W'(s[i]));
		send_numeral();
	endtask

	task automatic send_code(input logic [CODE_W-1:0] code);
		numeral = {code};
		send_numeral();
	endtask

	// Drop valid, let every predicted result come out, then let the block
	// idle before the register port is touched.
	task automatic wait_idle();
		@(negedge clk);
		chars_if.valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_format(input int b, input logic plus, input logic zero,
			input logic [1:0] wsel);
		wait_idle();
		write_register(REG_NUMBER_BASE, CFG_DATA_W'(b));
		write_register(REG_ALLOW_PLUS, CFG_DATA_W'(plus));
		write_register(REG_ALLOW_ZERO, CFG_DATA_W'(zero));
		write_register(REG_WIDTH_SELECT, CFG_DATA_W'(wsel));
		cur_base = b;
		cur_wsel = wsel;
	endtask

	// Builds one string. Most are numbers in the current base (36 when
	// it is larger): short ones, random values, values at or just under
	// the width maximum, and digit runs as long as the maximum needs or
	// one longer, some with a stray sign or zero in front or a character
	// swapped for junk. The rest is noise or a lone or trailing-junk sign.
	task automatic make_numeral();
		int          eff;
		int          n;
		int          kind;
		logic [63:0] lim;
		numeral = {};
		eff = (cur_base > 36) ? 36 : cur_base;
		lim = width_max(cur_wsel);
		kind = $urandom_range(0, 99);
		if (kind < 20 || (eff < 2 && kind < 50)) begin
			if ($urandom_range(0, 3) == 0)
				numeral.push_back(CH_PLUS);
			n = $urandom_range(0, 5);
			if (n == 0 && numeral.size() == 0)
				n = 1;
			repeat (n) numeral.push_back(noise_unit());
		end else if (eff < 2) begin
			// base one takes only zeros, base zero takes nothing
			repeat ($urandom_range(1, 3)) numeral.push_back(CH_ZERO);
		end else begin
			case ($urandom_range(0, 3))
				0: repeat ($urandom_range(1, 4))
					numeral.push_back(digit_char($urandom_range(0, eff - 1)));
				1: append_number(({$urandom, $urandom} >> $urandom_range(0, 63)) & lim, eff);
				2: begin
					append_number(lim - 64'($urandom_range(0, 2)), eff);
					// one more digit steps just over the limit
					if ($urandom_range(0, 1))
						numeral.push_back(digit_char($urandom_range(0, eff - 1)));
				end
				default: repeat (digits_needed(lim, eff) + $urandom_range(0, 1))
					numeral.push_back(digit_char($urandom_range(0, eff - 1)));
			endcase
			if ($urandom_range(0, 7) == 0)
				numeral.push_front(CH_PLUS);
			if ($urandom_range(0, 9) == 0)
				numeral.push_front(CH_ZERO);
			if ($urandom_range(0, 11) == 0)
				numeral[$urandom_range(0, numeral.size() - 1)] = noise_unit();
		end
	endtask

	// Result side: ready drops for random bursts while stalls are enabled.
	initial begin
		results_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (recv_stalls && $urandom_range(0, 5) == 0) begin
				results_if.ready = 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end
			results_if.ready = 1'b1;
		end
	end

	initial begin
		int b;
		int mode;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_NUMBER_BASE;
		cfg_data = '0;
		chars_if.valid = 1'b0;
		chars_if.code_unit = '0;
		chars_if.last_unit = 1'b0;
		units_sent = 0;
		send_gaps = 1'b0;
		recv_stalls = 1'b0;
		cur_base = int'(BASE_RESET);
		cur_wsel = WSEL_64;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset format: base ten, no sign, no leading zero, 64-bit limit.
		send_ascii("0");          // a lone zero is fine
		send_ascii("9");
		send_code('1);            // top code unit
		send_code('0);            // code zero
		send_ascii("+5");         // sign not allowed
		send_ascii("01");         // leading zero not allowed
		send_ascii("a");          // letter above the base

		// Base 36, sign and zeros allowed, 8-bit limit.
		set_format(36, 1'b1, 1'b1, WSEL_8);
		send_ascii("+");          // sign without any digit
		send_ascii("+Z");
		send_ascii("00");
		send_ascii("73");         // exactly 255
		send_ascii("74");         // one past the limit

		// Degenerate bases and the widest one.
		set_format(1, 1'b0, 1'b1, WSEL_16);
		send_ascii("00");         // base one: zeros only
		send_ascii("1");
		set_format(0, 1'b0, 1'b0, WSEL_16);
		send_ascii("0");          // base zero accepts no digit
		set_format(63, 1'b0, 1'b0, WSEL_32);
		send_ascii("z");          // above 36 every letter counts

		// Random phases, each with its own format and idling pattern.
		while (units_sent < UNIT_TARGET) begin
			case ($urandom_range(0, 9))
				0: b = 0;
				1: b = 1;
				2: b = 2;
				3: b = 36;
				4: b = 63;
				5: b = 10;
				6: b = 16;
				default: b = $urandom_range(2, 63);
			endcase
			set_format(b, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				2'($urandom_range(0, 3)));
			mode = $urandom_range(0, 3);
			send_gaps = (units_sent < CALM_AFTER) && mode[0];
			recv_stalls = (units_sent < CALM_AFTER) && mode[1];
			repeat ($urandom_range(8, 30)) begin
				make_numeral();
				send_numeral();
			end
		end

		wait_idle();
		if (mismatches == 0)
			$display("** unsigned_text_to_integer_parser_unit: PASSED **");
		else
			$display("** unsigned_text_to_integer_parser_unit: FAILED **");
		$finish;
	end

	// Hang guard, far beyond the slowest correct run.
	initial begin
		#6000000;
		$display("** unsigned_text_to_integer_parser_unit: FAILED **");
		$finish;
	end

endmodule
